### src/ccr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccr_pkg
// Shared types and constants for the closed Catmull-Rom point evaluator.
// ----------------------------------------------------------------------------
package ccr_pkg;

  localparam int COORD_W = 24;
  localparam int PARAM_W = 16;
  localparam int SEG_W   = 6;
  localparam int CFG_W   = 7;
  localparam int WF_W    = 53;
  localparam int WGT_W   = 26;
  localparam int PROD_W  = 50;
  localparam int ACC_W   = 52;
  localparam int NSTG    = 7;

  localparam int COORD_MAX      = 8388607;
  localparam int COORD_MIN      = -8388608;
  localparam int NUM_POINTS_RST = 4;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [WGT_W-1:0]   wgt_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  typedef struct packed {
    logic                      operation;
    logic [5:0]                point_index;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic [PARAM_W-1:0]        global_param;
  } in_req_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] curve_x;
    logic signed [COORD_W-1:0] curve_y;
    logic signed [COORD_W-1:0] curve_z;
    logic [SEG_W-1:0]          segment;
  } out_rsp_t;

  typedef struct packed {
    logic en_mul;
    logic en_sum;
    logic en_out;
  } blend_ctl_t;

endpackage

### src/ccr_point_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccr_point_mem
// Control point table, one write port and one registered read port.
// ----------------------------------------------------------------------------
module ccr_point_mem #(
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  ccr_pkg::point_t          wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output ccr_pkg::point_t          rdata
);

  ccr_pkg::point_t mem [DEPTH];
  ccr_pkg::point_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### src/ccr_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccr_blend
// One axis: four weight products, sum, round to Q15.8 and saturate.
// ----------------------------------------------------------------------------
module ccr_blend (
  input  logic                clk,
  input  ccr_pkg::blend_ctl_t ctl,
  input  ccr_pkg::wgt_t       wgt [4],
  input  ccr_pkg::coord_t     crd [4],
  output ccr_pkg::coord_t     res
);

  logic signed [ccr_pkg::PROD_W-1:0] prod_r   [4];
  logic signed [ccr_pkg::PROD_W-1:0] prod_nxt [4];
  logic signed [ccr_pkg::ACC_W-1:0]  acc_r;
  logic signed [ccr_pkg::ACC_W-1:0]  acc_nxt;
  logic signed [ccr_pkg::ACC_W-1:0]  rnd_c;
  ccr_pkg::coord_t                   res_r;
  ccr_pkg::coord_t                   res_nxt;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      prod_nxt[k] = ccr_pkg::PROD_W'(wgt[k]) * ccr_pkg::PROD_W'(crd[k]);
    end
    acc_nxt = (ccr_pkg::ACC_W'(prod_r[0]) + ccr_pkg::ACC_W'(prod_r[1]))
            + (ccr_pkg::ACC_W'(prod_r[2]) + ccr_pkg::ACC_W'(prod_r[3]));
    // round half up at bit 24, floor via arithmetic shift
    rnd_c = (acc_r + ccr_pkg::ACC_W'(2 ** 23)) >>> 24;
    if (rnd_c > ccr_pkg::ACC_W'(ccr_pkg::COORD_MAX)) begin
      res_nxt = ccr_pkg::COORD_W'(ccr_pkg::COORD_MAX);
    end else if (rnd_c < ccr_pkg::ACC_W'(ccr_pkg::COORD_MIN)) begin
      res_nxt = ccr_pkg::COORD_W'(ccr_pkg::COORD_MIN);
    end else begin
      res_nxt = rnd_c[ccr_pkg::COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en_mul) begin
      prod_r <= prod_nxt;
    end
    if (ctl.en_sum) begin
      acc_r <= acc_nxt;
    end
    if (ctl.en_out) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

### src/closed_catmull_rom_point_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// closed_catmull_rom_point_eval
// Closed-loop Catmull-Rom curve evaluator over a table of 3D control points.
//
// in channel: a load request (operation 0) writes point_x/y/z into slot
// point_index; an evaluate request (operation 1) returns one curve point for
// global_param. Load requests give no result. cfg_we/cfg_wdata set the number
// of points in the loop, written only while the block is idle. The block
// itself does not enforce this; the user is bound to it. An accepted evaluate
// request raises out_valid once it reaches the last stage.
// Throughput: one request per cycle while out_stall is low, set by the
// seven stage pipeline (index/table read, square, cube, weights, products,
// sum, round/saturate) with four copies of the table so that all four
// neighbours are read in the same cycle. A load is written at its accept
// edge, so any later evaluate sees it.
// Reset clears every stage valid bit and sets the point count to 4; table
// contents stay undefined until loaded.
// When out_stall is high, earlier stages keep filling empty slots; in_stall
// rises only once all seven stages hold a request.
// ----------------------------------------------------------------------------
module closed_catmull_rom_point_eval #(
  parameter int MAX_POINTS = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  ccr_pkg::in_req_t         in_req,
  output logic                     out_valid,
  input  logic                     out_stall,
  output ccr_pkg::out_rsp_t        out_rsp,
  input  logic                     cfg_we,
  input  logic [ccr_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int AW  = $clog2(MAX_POINTS);
  localparam int NW  = ($clog2(MAX_POINTS + 1) > ccr_pkg::CFG_W) ?
                       $clog2(MAX_POINTS + 1) : ccr_pkg::CFG_W;
  localparam int PW  = NW + ccr_pkg::PARAM_W;
  localparam int NST = ccr_pkg::NSTG;

  // point count
  logic [NW-1:0] n_r;
  logic [NW-1:0] n_nxt;
  logic [NW-1:0] cfg_ext;

  // stage control
  logic [NST:1]   vld_r;
  logic [NST:1]   vld_nxt;
  logic [NST+1:1] en;
  logic           in_acc;
  logic           is_eval;

  // index computation
  logic [PW-1:0]  prod_c;
  logic [NW-1:0]  seg_c;
  logic [NW-1:0]  idx_c [4];
  logic [NW-1:0]  inc2_c;
  logic [NW-1:0]  inc3_c;
  logic           mem_we;
  ccr_pkg::point_t wpt;
  ccr_pkg::point_t rd_pt [4];

  // stage 1..7 payload
  logic [ccr_pkg::PARAM_W-1:0] t_s1_r, t_s2_r, t_s3_r;
  logic [31:0]                 tsq_s2_r, tsq_s3_r;
  logic [47:0]                 tcu_s3_r;
  logic [ccr_pkg::SEG_W-1:0]   seg_s1_r, seg_s2_r, seg_s3_r, seg_s4_r;
  logic [ccr_pkg::SEG_W-1:0]   seg_s5_r, seg_s6_r, seg_s7_r;
  ccr_pkg::point_t             pts_s2_r [4];
  ccr_pkg::point_t             pts_s3_r [4];
  ccr_pkg::point_t             pts_s4_r [4];
  ccr_pkg::wgt_t               wgt_s4_r [4];
  ccr_pkg::wgt_t               wgt_nxt  [4];

  // weight arithmetic
  logic signed [ccr_pkg::WF_W-1:0] tl_c, ts_c, tc_c;
  logic signed [ccr_pkg::WF_W-1:0] wf_c  [4];
  logic signed [ccr_pkg::WF_W-1:0] wq_c  [4];

  ccr_pkg::blend_ctl_t bctl;
  ccr_pkg::coord_t     crd_x [4];
  ccr_pkg::coord_t     crd_y [4];
  ccr_pkg::coord_t     crd_z [4];
  ccr_pkg::coord_t     res_x, res_y, res_z;

  // config register, clamped to 1..MAX_POINTS on write
  always_comb begin
    cfg_ext = NW'(cfg_wdata);
    if (cfg_ext == '0) begin
      n_nxt = NW'(1);
    end else if (cfg_ext > NW'(MAX_POINTS)) begin
      n_nxt = NW'(MAX_POINTS);
    end else begin
      n_nxt = cfg_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= NW'(ccr_pkg::NUM_POINTS_RST);
    end else if (cfg_we) begin
      n_r <= n_nxt;
    end
  end

  // stage enables, a stage loads when empty or when it drains
  always_comb begin
    en[NST+1] = !out_stall;
    for (int k = NST; k >= 1; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign in_stall = !en[1];
  assign in_acc   = in_valid && en[1];
  assign is_eval  = (in_req.operation == ccr_pkg::OP_EVAL);

  always_comb begin
    vld_nxt = vld_r;
    for (int k = NST; k >= 2; k--) begin
      if (en[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
    if (en[1]) begin
      vld_nxt[1] = in_valid && is_eval;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // segment, fraction and wrapped neighbours
  always_comb begin
    prod_c   = PW'(n_r) * PW'(in_req.global_param);
    seg_c    = prod_c[PW-1:ccr_pkg::PARAM_W];
    idx_c[0] = (seg_c == '0) ? (n_r - NW'(1)) : (seg_c - NW'(1));
    idx_c[1] = seg_c;
    inc2_c   = seg_c + NW'(1);
    idx_c[2] = (inc2_c == n_r) ? '0 : inc2_c;
    inc3_c   = idx_c[2] + NW'(1);
    idx_c[3] = (inc3_c == n_r) ? '0 : inc3_c;
  end

  assign mem_we = in_acc && (in_req.operation == ccr_pkg::OP_LOAD)
                  && (32'(in_req.point_index) < 32'(MAX_POINTS));
  assign wpt    = '{x: in_req.point_x, y: in_req.point_y, z: in_req.point_z};

  for (genvar g = 0; g < 4; g++) begin : g_mem
    ccr_point_mem #(
      .DEPTH(MAX_POINTS)
    ) u_mem (
      .clk  (clk),
      .we   (mem_we),
      .waddr(AW'(in_req.point_index)),
      .wdata(wpt),
      .re   (en[1]),
      .raddr(idx_c[g][AW-1:0]),
      .rdata(rd_pt[g])
    );
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (en[1]) begin
      t_s1_r   <= prod_c[ccr_pkg::PARAM_W-1:0];
      seg_s1_r <= seg_c[ccr_pkg::SEG_W-1:0];
    end
  end

  // stage 2: square
  always_ff @(posedge clk) begin
    if (en[2]) begin
      t_s2_r   <= t_s1_r;
      tsq_s2_r <= 32'(t_s1_r) * 32'(t_s1_r);
      seg_s2_r <= seg_s1_r;
      pts_s2_r <= rd_pt;
    end
  end

  // stage 3: cube
  always_ff @(posedge clk) begin
    if (en[3]) begin
      t_s3_r   <= t_s2_r;
      tsq_s3_r <= tsq_s2_r;
      tcu_s3_r <= 48'(tsq_s2_r) * 48'(t_s2_r);
      seg_s3_r <= seg_s2_r;
      pts_s3_r <= pts_s2_r;
    end
  end

  // stage 4: doubled weights in Q.48, rounded to Q.24
  always_comb begin
    tl_c  = ccr_pkg::WF_W'(t_s3_r);
    ts_c  = ccr_pkg::WF_W'(tsq_s3_r);
    tc_c  = ccr_pkg::WF_W'(tcu_s3_r);
    wf_c[0] = (ts_c <<< 17) - tc_c - (tl_c <<< 32);
    wf_c[1] = (tc_c + (tc_c <<< 1)) - ((ts_c <<< 18) + (ts_c <<< 16))
            + (ccr_pkg::WF_W'(1) <<< 49);
    wf_c[2] = (ts_c <<< 18) - (tc_c + (tc_c <<< 1)) + (tl_c <<< 32);
    wf_c[3] = tc_c - (ts_c <<< 16);
    for (int k = 0; k < 4; k++) begin
      wq_c[k]    = (wf_c[k] + ccr_pkg::WF_W'(2 ** 24)) >>> 25;
      wgt_nxt[k] = wq_c[k][ccr_pkg::WGT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      wgt_s4_r <= wgt_nxt;
      seg_s4_r <= seg_s3_r;
      pts_s4_r <= pts_s3_r;
    end
  end

  // stages 5 to 7
  assign bctl = '{en_mul: en[5], en_sum: en[6], en_out: en[7]};

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      crd_x[k] = pts_s4_r[k].x;
      crd_y[k] = pts_s4_r[k].y;
      crd_z[k] = pts_s4_r[k].z;
    end
  end

  ccr_blend u_blend_x (.clk(clk), .ctl(bctl), .wgt(wgt_s4_r), .crd(crd_x), .res(res_x));
  ccr_blend u_blend_y (.clk(clk), .ctl(bctl), .wgt(wgt_s4_r), .crd(crd_y), .res(res_y));
  ccr_blend u_blend_z (.clk(clk), .ctl(bctl), .wgt(wgt_s4_r), .crd(crd_z), .res(res_z));

  always_ff @(posedge clk) begin
    if (en[5]) begin
      seg_s5_r <= seg_s4_r;
    end
    if (en[6]) begin
      seg_s6_r <= seg_s5_r;
    end
    if (en[7]) begin
      seg_s7_r <= seg_s6_r;
    end
  end

  assign out_valid = vld_r[NST];
  assign out_rsp   = '{curve_x: res_x, curve_y: res_y, curve_z: res_z,
                       segment: seg_s7_r};

  // checks
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&vld_r))
    else $error("input stalled while a stage is empty");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && is_eval) |->
      (idx_c[0] < n_r) && (idx_c[1] < n_r) && (idx_c[2] < n_r) && (idx_c[3] < n_r))
    else $error("neighbour index outside point count");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[NST-1] && !en[NST]) |=> vld_r[NST-1])
    else $error("stalled request dropped from sum stage");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[NST] && out_stall) |=> (vld_r[NST] && $stable(seg_s7_r)))
    else $error("stalled result changed");

endmodule

### tb/sv/closed_catmull_rom_point_eval_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// closed_catmull_rom_point_eval_test
// Self-checking bench for the closed-loop Catmull-Rom point evaluator. Load
// and evaluate requests go in through a valid/stall channel. An internal copy
// of the point table and of the point count predicts each curve point. A
// checker compares every result, field by field, with the oldest prediction.
// Directed tests cover the default count, the count extremes, saturation and
// reloading a slot. A random stream then runs over several point counts with
// random idling on both sides in all phases but one.
// ----------------------------------------------------------------------------
module closed_catmull_rom_point_eval_test;

  localparam int MAX_PTS     = 64;
  localparam int LATENCY     = 7;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_ITEMS = 125;

  localparam ccr_pkg::coord_t CRD_MAX = ccr_pkg::coord_t'(ccr_pkg::COORD_MAX);
  localparam ccr_pkg::coord_t CRD_MIN = ccr_pkg::coord_t'(ccr_pkg::COORD_MIN);

  logic                      clk       = 1'b0;
  logic                      rst_n     = 1'b0;
  logic                      in_valid  = 1'b0;
  logic                      in_stall;
  ccr_pkg::in_req_t          in_req    = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  ccr_pkg::out_rsp_t         out_rsp;
  logic                      cfg_we    = 1'b0;
  logic [ccr_pkg::CFG_W-1:0] cfg_wdata = '0;

  ccr_pkg::point_t           point_table [MAX_PTS];
  bit                        slot_written [MAX_PTS];
  logic [ccr_pkg::CFG_W-1:0] point_count = ccr_pkg::CFG_W'(ccr_pkg::NUM_POINTS_RST);
  ccr_pkg::out_rsp_t         expected_points [$];
  ccr_pkg::out_rsp_t         oldest_point;
  bit                        idle_enable = 1'b1;
  int                        error_count = 0;
  int                        cycle_count = 0;

  closed_catmull_rom_point_eval #(
    .MAX_POINTS(MAX_PTS)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_rsp  (out_rsp),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  function automatic int effective_count();
    int n;
    n = int'(point_count);
    if (n == 0) n = 1;
    if (n > MAX_PTS) n = MAX_PTS;
    return n;
  endfunction

  function automatic ccr_pkg::coord_t saturate_coord(longint v);
    if (v > ccr_pkg::COORD_MAX) v = ccr_pkg::COORD_MAX;
    if (v < ccr_pkg::COORD_MIN) v = ccr_pkg::COORD_MIN;
    return ccr_pkg::coord_t'(v);
  endfunction

  function automatic ccr_pkg::out_rsp_t predict_curve_point(
      logic [ccr_pkg::PARAM_W-1:0] param);
    int                n;
    int                seg;
    int                slot;
    longint            prod;
    longint            t;
    longint            t2;
    longint            t3;
    longint            acc;
    longint            w [4];
    longint            c [4][3];
    ccr_pkg::coord_t   res [3];
    ccr_pkg::out_rsp_t r;
    n    = effective_count();
    prod = longint'(n) * longint'(param);
    seg  = int'(prod >>> 16);
    t    = prod & 64'hFFFF;
    for (int k = 0; k < 4; k++) begin
      slot    = (seg + n - 1 + k) % n;
      c[k][0] = longint'(point_table[slot].x);
      c[k][1] = longint'(point_table[slot].y);
      c[k][2] = longint'(point_table[slot].z);
    end
    t2   = t * t * 65536;
    t3   = t * t * t;
    w[0] = -t3 + 2 * t2 - t * 64'sd4294967296;
    w[1] = 3 * t3 - 5 * t2 + 64'sd562949953421312;
    w[2] = -3 * t3 + 4 * t2 + t * 64'sd4294967296;
    w[3] = t3 - t2;
    for (int k = 0; k < 4; k++) begin
      w[k] = (w[k] + 64'sd16777216) >>> 25;
    end
    for (int a = 0; a < 3; a++) begin
      acc = 0;
      for (int k = 0; k < 4; k++) begin
        acc += w[k] * c[k][a];
      end
      res[a] = saturate_coord((acc + 64'sd8388608) >>> 24);
    end
    r.curve_x = res[0];
    r.curve_y = res[1];
    r.curve_z = res[2];
    r.segment = ccr_pkg::SEG_W'(seg);
    return r;
  endfunction

  function automatic ccr_pkg::coord_t rand_coord();
    case ($urandom_range(7))
      0: return CRD_MAX;
      1: return CRD_MIN;
      2: return ccr_pkg::coord_t'(int'($urandom_range(4096)) - 2048);
      default: return ccr_pkg::coord_t'($urandom);
    endcase
  endfunction

  function automatic logic [ccr_pkg::PARAM_W-1:0] rand_param();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return ccr_pkg::PARAM_W'($urandom);
    endcase
  endfunction

  function automatic ccr_pkg::in_req_t load_req(int slot, ccr_pkg::coord_t x,
                                                ccr_pkg::coord_t y, ccr_pkg::coord_t z);
    ccr_pkg::in_req_t r;
    r.operation    = ccr_pkg::OP_LOAD;
    r.point_index  = 6'(slot);
    r.point_x      = x;
    r.point_y      = y;
    r.point_z      = z;
    r.global_param = ccr_pkg::PARAM_W'($urandom);
    return r;
  endfunction

  function automatic ccr_pkg::in_req_t eval_req(logic [ccr_pkg::PARAM_W-1:0] param);
    ccr_pkg::in_req_t r;
    r.operation    = ccr_pkg::OP_EVAL;
    r.point_index  = 6'($urandom);
    r.point_x      = ccr_pkg::coord_t'($urandom);
    r.point_y      = ccr_pkg::coord_t'($urandom);
    r.point_z      = ccr_pkg::coord_t'($urandom);
    r.global_param = param;
    return r;
  endfunction

  task automatic send_request(ccr_pkg::in_req_t r);
    while (idle_enable && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_req   <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (r.operation == ccr_pkg::OP_LOAD) begin
      point_table[r.point_index]  = '{r.point_x, r.point_y, r.point_z};
      slot_written[r.point_index] = 1'b1;
    end else begin
      expected_points.insert(expected_points.size(), predict_curve_point(r.global_param));
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (LATENCY + 3) @(posedge clk);
  endtask

  // new count, then fill any slot of the loop not loaded yet
  task automatic set_point_count(int v);
    wait_idle();
    cfg_wdata <= ccr_pkg::CFG_W'(v);
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we      <= 1'b0;
    point_count = ccr_pkg::CFG_W'(v);
    for (int i = 0; i < effective_count(); i++) begin
      if (!slot_written[i]) send_request(load_req(i, rand_coord(), rand_coord(), rand_coord()));
    end
  endtask

  task automatic test_default_count();
    send_request(load_req(0, CRD_MAX, CRD_MAX, CRD_MAX));
    send_request(load_req(1, CRD_MIN, CRD_MIN, CRD_MIN));
    send_request(load_req(2, CRD_MAX, CRD_MIN, '0));
    send_request(load_req(3, '0, CRD_MIN, CRD_MAX));
    send_request(eval_req(16'h0000));
    send_request(eval_req(16'hFFFF));
    send_request(eval_req(16'h0001));
    send_request(eval_req(16'h2000));
    send_request(eval_req(16'h4000));
    send_request(eval_req(16'h8000));
    send_request(eval_req(16'hC000));
    // reload a slot and read it in the next request
    send_request(load_req(1, '0, '0, '0));
    send_request(eval_req(16'h4800));
    send_request(load_req(3, rand_coord(), rand_coord(), rand_coord()));
    send_request(eval_req(16'hE000));
  endtask

  task automatic test_count_extremes();
    int counts [7] = '{0, 1, 2, 3, 64, 65, 127};
    foreach (counts[i]) begin
      set_point_count(counts[i]);
      send_request(eval_req(16'h0000));
      send_request(eval_req(16'hFFFF));
      send_request(eval_req(ccr_pkg::PARAM_W'($urandom)));
    end
  endtask

  task automatic test_random_stream();
    int n;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: n = $urandom_range(64, 1);
        1: n = 64;
        2: n = 127;
        3: n = 0;
        4: n = 1;
        5: n = 4;
        6: n = $urandom_range(127, 0);
        default: n = $urandom_range(63, 2);
      endcase
      set_point_count(n);
      idle_enable = (phase != 5);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(99) < 30) begin
          send_request(load_req($urandom_range(MAX_PTS - 1), rand_coord(), rand_coord(),
                                rand_coord()));
        end else begin
          send_request(eval_req(rand_param()));
        end
      end
    end
    idle_enable = 1'b1;
  endtask

  task automatic check_field(string name, logic [ccr_pkg::COORD_W-1:0] expv,
                             logic [ccr_pkg::COORD_W-1:0] actv);
    if (expv !== actv) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, expv, actv);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_points.size() == 0) begin
        $display("%0t: result with no request pending, expected none actual %h", $time,
                 out_rsp);
        error_count++;
      end else begin
        oldest_point = expected_points.pop_front();
        check_field("curve_x", oldest_point.curve_x, out_rsp.curve_x);
        check_field("curve_y", oldest_point.curve_y, out_rsp.curve_y);
        check_field("curve_z", oldest_point.curve_z, out_rsp.curve_z);
        check_field("segment", ccr_pkg::COORD_W'(oldest_point.segment),
                    ccr_pkg::COORD_W'(out_rsp.segment));
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= idle_enable && ($urandom_range(99) < 28);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("closed_catmull_rom_point_eval_test NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_count();
    test_count_extremes();
    test_random_stream();
    wait_idle();
    if (error_count == 0) begin
      $display("closed_catmull_rom_point_eval_test OK");
    end else begin
      $display("closed_catmull_rom_point_eval_test NOT OK");
    end
    $finish;
  end

endmodule

### filelist.f
src/ccr_pkg.sv
src/ccr_point_mem.sv
src/ccr_blend.sv
src/closed_catmull_rom_point_eval.sv
tb/sv/closed_catmull_rom_point_eval_test.sv
